FILE: rtl/fsp_pkg.sv
// fsp_pkg: shared types and constants for the format string printer.
// Used by fsp_ctrl, fsp_datapath, format_string_printer and fsp_checker.
package fsp_pkg;

  // request types
  localparam logic [1:0] REQ_FMT  = 2'd0;
  localparam logic [1:0] REQ_NUM  = 2'd1;
  localparam logic [1:0] REQ_STR  = 2'd2;
  localparam logic [1:0] REQ_NULL = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // output byte sources
  localparam logic [2:0] SRC_ZERO  = 3'd0;
  localparam logic [2:0] SRC_BYTE  = 3'd1;
  localparam logic [2:0] SRC_WORD  = 3'd2;
  localparam logic [2:0] SRC_PCT   = 3'd3;
  localparam logic [2:0] SRC_DASH  = 3'd4;
  localparam logic [2:0] SRC_NULL  = 3'd5;
  localparam logic [2:0] SRC_DIGIT = 3'd6;

  // characters
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;

  localparam int NullLen = 6;
  localparam int DigitDepth = 10;
  localparam int CountW = 31;

  typedef struct packed {
    logic       latch;       // capture the accepted request
    logic       num_signed;  // argument is signed (d, i)
    logic       load;        // write one result to the output register
    logic [1:0] kind;
    logic [2:0] src;
    logic [2:0] null_idx;
    logic       last;
    logic       clear;       // count restarts after this result
    logic       div_step;    // peel one decimal digit
    logic       dig_pop;     // step the digit read pointer down
  } fsp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic arg_msb;
    logic div_last;
    logic dig_last;
    logic b_zero;
    logic b_pct;
    logic b_c;
    logic b_s;
    logic b_di;
    logic b_u;
  } fsp_status_t;

  function automatic logic [7:0] null_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h28;  // (
      3'd1: ch = 8'h6E;  // n
      3'd2: ch = 8'h75;  // u
      3'd3: ch = 8'h6C;  // l
      3'd4: ch = 8'h6C;  // l
      3'd5: ch = 8'h29;  // )
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/fsp_datapath.sv
// fsp_datapath: request latches, decimal digit extraction, character
// counter and output register. Depends on fsp_pkg.
module fsp_datapath #(
  parameter int ARG_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [7:0]                data_byte,
  input  logic [31:0]               arg_word,
  input  fsp_pkg::fsp_cmd_t         cmd,
  output fsp_pkg::fsp_status_t      st,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_byte,
  output logic [fsp_pkg::CountW-1:0] char_count,
  output logic                      is_last
);

  localparam int EffBits = (ARG_BITS < 32) ? ARG_BITS : 32;
  localparam logic [fsp_pkg::CountW-1:0] CountMax = '1;

  logic [7:0]         byte_q;
  logic [7:0]         word_low;
  logic [EffBits-1:0] mag;
  logic [3:0]         digit_store [fsp_pkg::DigitDepth];
  logic [3:0]         digit_total;
  logic [3:0]         rp;
  logic [fsp_pkg::CountW-1:0] written_total;

  logic [EffBits-1:0] arg_eff;
  logic               arg_neg;
  logic [31:0]        mag32;
  logic [63:0]        prod;
  logic [28:0]        quot;
  logic [31:0]        rem;
  logic [fsp_pkg::CountW-1:0] cnt_inc;
  logic [7:0]         byte_sel;

  assign arg_eff = arg_word[EffBits-1:0];
  assign arg_neg = cmd.num_signed & arg_eff[EffBits-1];

  // divide by ten through the reciprocal, exact for any 32-bit value
  assign mag32 = 32'(mag);
  assign prod  = 64'(mag32) * 64'hCCCC_CCCD;
  assign quot  = prod[63:35];
  assign rem   = mag32 - (32'({quot, 3'b000}) + 32'({quot, 1'b0}));

  assign cnt_inc = (written_total == CountMax) ? written_total : written_total + 1'b1;

  always_comb begin
    case (cmd.src)
      fsp_pkg::SRC_ZERO:  byte_sel = 8'h00;
      fsp_pkg::SRC_BYTE:  byte_sel = byte_q;
      fsp_pkg::SRC_WORD:  byte_sel = word_low;
      fsp_pkg::SRC_PCT:   byte_sel = fsp_pkg::CH_PCT;
      fsp_pkg::SRC_DASH:  byte_sel = fsp_pkg::CH_DASH;
      fsp_pkg::SRC_NULL:  byte_sel = fsp_pkg::null_char(cmd.null_idx);
      fsp_pkg::SRC_DIGIT: byte_sel = fsp_pkg::CH_DIGIT0 + 8'(digit_store[rp]);
      default:            byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    st.out_free = ~out_valid | out_ready;
    st.arg_msb  = arg_eff[EffBits-1];
    st.div_last = (quot == '0) || (digit_total == 4'(fsp_pkg::DigitDepth - 1));
    st.dig_last = (rp == '0);
    st.b_zero   = (data_byte == 8'h00);
    st.b_pct    = (data_byte == fsp_pkg::CH_PCT);
    st.b_c      = (data_byte == fsp_pkg::CH_C);
    st.b_s      = (data_byte == fsp_pkg::CH_S);
    st.b_di     = (data_byte == fsp_pkg::CH_D) || (data_byte == fsp_pkg::CH_I);
    st.b_u      = (data_byte == fsp_pkg::CH_U);
  end

  // request latches and digit store
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_q   <= data_byte;
      word_low <= arg_word[7:0];
      mag      <= arg_neg ? (~arg_eff + 1'b1) : arg_eff;
    end
    if (cmd.div_step) begin
      digit_store[digit_total] <= rem[3:0];
      mag <= EffBits'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_total <= '0;
      rp <= '0;
    end else if (cmd.latch) begin
      digit_total <= '0;
    end else if (cmd.div_step) begin
      digit_total <= digit_total + 1'b1;
      rp <= digit_total;
    end else if (cmd.dig_pop) begin
      rp <= rp - 1'b1;
    end
  end

  // character counter
  always_ff @(posedge clk) begin
    if (rst) begin
      written_total <= '0;
    end else if (cmd.load) begin
      if (cmd.clear) begin
        written_total <= '0;
      end else if (cmd.kind == fsp_pkg::KIND_BYTE) begin
        written_total <= cnt_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind   <= cmd.kind;
      out_byte   <= byte_sel;
      char_count <= (cmd.kind == fsp_pkg::KIND_BYTE) ? cnt_inc : written_total;
      is_last    <= cmd.last;
    end
  end

endmodule

FILE: rtl/fsp_ctrl.sv
// fsp_ctrl: parse mode tracking and result sequencing state machine.
// Drives fsp_datapath through fsp_pkg::fsp_cmd_t; depends on fsp_pkg.
module fsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  fsp_pkg::fsp_status_t st,
  output fsp_pkg::fsp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ONE  = 3'd1;
  localparam logic [2:0] ST_PCT  = 3'd2;
  localparam logic [2:0] ST_NULL = 3'd3;
  localparam logic [2:0] ST_SIGN = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DIGS = 3'd6;

  localparam logic [2:0] MODE_PLAIN  = 3'd0;
  localparam logic [2:0] MODE_AFTER  = 3'd1;
  localparam logic [2:0] MODE_CHAR   = 3'd2;
  localparam logic [2:0] MODE_SIGNED = 3'd3;
  localparam logic [2:0] MODE_UNS    = 3'd4;
  localparam logic [2:0] MODE_STR    = 3'd5;
  localparam logic [2:0] MODE_IN_STR = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] parse_mode, parse_mode_next;
  logic [1:0] pend_kind, pend_kind_next;
  logic [2:0] pend_src, pend_src_next;
  logic       pend_clear, pend_clear_next;
  logic [2:0] nidx, nidx_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_next      = state;
    parse_mode_next = parse_mode;
    pend_kind_next  = pend_kind;
    pend_src_next   = pend_src;
    pend_clear_next = pend_clear;
    nidx_next       = nidx;
    cmd             = '0;
    cmd.num_signed  = (parse_mode == MODE_SIGNED);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          // plain byte result unless a branch below overrides it
          pend_kind_next  = fsp_pkg::KIND_BYTE;
          pend_src_next   = fsp_pkg::SRC_BYTE;
          pend_clear_next = 1'b0;
          case (parse_mode)
            MODE_PLAIN: begin
              if (req_type != fsp_pkg::REQ_FMT) begin
                state_next = ST_ONE;
                pend_kind_next = fsp_pkg::KIND_ERR;
                pend_src_next = fsp_pkg::SRC_ZERO;
                pend_clear_next = 1'b1;
              end else if (st.b_zero) begin
                state_next = ST_ONE;
                pend_kind_next = fsp_pkg::KIND_END;
                pend_src_next = fsp_pkg::SRC_ZERO;
                pend_clear_next = 1'b1;
              end else if (st.b_pct) begin
                parse_mode_next = MODE_AFTER;
              end else begin
                state_next = ST_ONE;
              end
            end
            MODE_AFTER: begin
              parse_mode_next = MODE_PLAIN;
              if (req_type != fsp_pkg::REQ_FMT || st.b_zero) begin
                state_next = ST_ONE;
                pend_kind_next = fsp_pkg::KIND_ERR;
                pend_src_next = fsp_pkg::SRC_ZERO;
                pend_clear_next = 1'b1;
              end else if (st.b_c) begin
                parse_mode_next = MODE_CHAR;
              end else if (st.b_s) begin
                parse_mode_next = MODE_STR;
              end else if (st.b_di) begin
                parse_mode_next = MODE_SIGNED;
              end else if (st.b_u) begin
                parse_mode_next = MODE_UNS;
              end else if (st.b_pct) begin
                state_next = ST_ONE;
                pend_src_next = fsp_pkg::SRC_PCT;
              end else begin
                // unknown specifier: '%' then the character
                state_next = ST_PCT;
              end
            end
            MODE_CHAR, MODE_SIGNED, MODE_UNS: begin
              parse_mode_next = MODE_PLAIN;
              if (req_type != fsp_pkg::REQ_NUM) begin
                state_next = ST_ONE;
                pend_kind_next = fsp_pkg::KIND_ERR;
                pend_src_next = fsp_pkg::SRC_ZERO;
                pend_clear_next = 1'b1;
              end else if (parse_mode == MODE_CHAR) begin
                state_next = ST_ONE;
                pend_src_next = fsp_pkg::SRC_WORD;
              end else if (cmd.num_signed && st.arg_msb) begin
                state_next = ST_SIGN;
              end else begin
                state_next = ST_DIV;
              end
            end
            MODE_STR, MODE_IN_STR: begin
              if (req_type == fsp_pkg::REQ_NULL && parse_mode == MODE_STR) begin
                parse_mode_next = MODE_PLAIN;
                state_next = ST_NULL;
                nidx_next = '0;
              end else if (req_type != fsp_pkg::REQ_STR) begin
                parse_mode_next = MODE_PLAIN;
                state_next = ST_ONE;
                pend_kind_next = fsp_pkg::KIND_ERR;
                pend_src_next = fsp_pkg::SRC_ZERO;
                pend_clear_next = 1'b1;
              end else if (st.b_zero) begin
                parse_mode_next = MODE_PLAIN;
              end else begin
                parse_mode_next = MODE_IN_STR;
                state_next = ST_ONE;
              end
            end
            default: begin
              parse_mode_next = MODE_PLAIN;
              state_next = ST_ONE;
              pend_kind_next = fsp_pkg::KIND_ERR;
              pend_src_next = fsp_pkg::SRC_ZERO;
              pend_clear_next = 1'b1;
            end
          endcase
        end
      end
      ST_ONE: begin
        cmd.kind  = pend_kind;
        cmd.src   = pend_src;
        cmd.clear = pend_clear;
        cmd.last  = 1'b1;
        if (st.out_free) begin
          cmd.load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_PCT: begin
        cmd.kind = fsp_pkg::KIND_BYTE;
        cmd.src  = fsp_pkg::SRC_PCT;
        if (st.out_free) begin
          cmd.load = 1'b1;
          state_next = ST_ONE;
        end
      end
      ST_NULL: begin
        cmd.kind     = fsp_pkg::KIND_BYTE;
        cmd.src      = fsp_pkg::SRC_NULL;
        cmd.null_idx = nidx;
        cmd.last     = (nidx == 3'(fsp_pkg::NullLen - 1));
        if (st.out_free) begin
          cmd.load = 1'b1;
          nidx_next = nidx + 1'b1;
          if (cmd.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SIGN: begin
        cmd.kind = fsp_pkg::KIND_BYTE;
        cmd.src  = fsp_pkg::SRC_DASH;
        if (st.out_free) begin
          cmd.load = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_DIGS;
        end
      end
      ST_DIGS: begin
        cmd.kind = fsp_pkg::KIND_BYTE;
        cmd.src  = fsp_pkg::SRC_DIGIT;
        cmd.last = st.dig_last;
        if (st.out_free) begin
          cmd.load = 1'b1;
          cmd.dig_pop = 1'b1;
          if (st.dig_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      parse_mode <= MODE_PLAIN;
    end else begin
      state      <= state_next;
      parse_mode <= parse_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind  <= pend_kind_next;
    pend_src   <= pend_src_next;
    pend_clear <= pend_clear_next;
    nidx       <= nidx_next;
  end

endmodule

FILE: rtl/format_string_printer.sv
// format_string_printer: top level of the printf-subset formatter.
// Instantiates fsp_ctrl and fsp_datapath; depends on fsp_pkg.
//
// Input channel (in_valid/in_ready): one request per handshake, either a
// format byte, a numeric or char argument, a string argument byte or a
// null string marker (req_type). Output channel (out_valid/out_ready):
// result items, one per handshake, with is_last on the final result of
// each request.
// Timing: a request is taken only while the sequencer is idle. Except for
// an integer, the sequencer state entered on acceptance loads the first
// result into the output register, and the following results one per cycle
// while the output register is free. An integer first gives a '-' if it is
// negative; its decimal digits are peeled off by one reciprocal multiply per
// cycle, least significant first, then read back most significant first.
// Requests that only change the parse mode give no result.
// Reset clears the parse mode, the character count and the output valid.
// If the receiver stalls, the result waits in the output register and the
// sequencer holds; a new request can still be taken whenever the
// sequencer has finished the previous one.
module format_string_printer #(
  parameter int ARG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic [31:0] arg_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [30:0] char_count,
  output logic        is_last
);

  fsp_pkg::fsp_cmd_t    cmd;
  fsp_pkg::fsp_status_t st;

  fsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .st       (st),
    .cmd      (cmd)
  );

  fsp_datapath #(
    .ARG_BITS (ARG_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .arg_word   (arg_word),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .char_count (char_count),
    .is_last    (is_last)
  );

endmodule

FILE: rtl/fsp_checker.sv
// fsp_checker: port-level assertions for format_string_printer, bound in
// below. Depends on fsp_pkg.
module fsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [30:0] char_count,
  input logic        is_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(char_count) && $stable(is_last))
    else $error("stalled result changed");

  // end and error results close their request and carry no byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == fsp_pkg::KIND_END || out_kind == fsp_pkg::KIND_ERR)
      |-> is_last && out_byte == 8'h00)
    else $error("status result malformed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind == fsp_pkg::KIND_BYTE || out_kind == fsp_pkg::KIND_END
      || out_kind == fsp_pkg::KIND_ERR)
    else $error("undefined result kind");

  // a written character is always counted
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == fsp_pkg::KIND_BYTE |-> char_count != '0)
    else $error("byte result with zero count");

endmodule

bind format_string_printer fsp_checker u_fsp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_kind   (out_kind),
  .out_byte   (out_byte),
  .char_count (char_count),
  .is_last    (is_last)
);

FILE: tb/tb_format_string_printer.sv
// tb_format_string_printer: self-checking testbench for the printf-subset formatter.
// Sends format, argument and string requests, predicts every output result in the bench
// and checks it on the output channel. Depends on fsp_pkg and format_string_printer.
module tb_format_string_printer;

  typedef enum logic [2:0] {
    PM_TEXT, PM_PCT, PM_CHAR, PM_SIGNED, PM_UNSIGNED, PM_STR_OPEN, PM_STR_BODY
  } parse_mode_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [7:0]                 ch;
    logic [fsp_pkg::CountW-1:0] count;
    logic                       last;
  } print_result_t;

  localparam logic [fsp_pkg::CountW-1:0] COUNT_SAT = '1;
  localparam logic [8*fsp_pkg::NullLen-1:0] NULL_TEXT = "(null)";

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 req_type = fsp_pkg::REQ_FMT;
  logic [7:0]                 data_byte = 8'h00;
  logic [31:0]                arg_word = 32'h0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 out_kind;
  logic [7:0]                 out_byte;
  logic [fsp_pkg::CountW-1:0] char_count;
  logic                       is_last;

  print_result_t              queued_output[$];
  parse_mode_t                pred_mode = PM_TEXT;
  logic [fsp_pkg::CountW-1:0] pred_written = '0;
  int                         errors = 0;
  int                         sent_count = 0;
  int                         send_idle = 38;
  int                         recv_idle = 51;

  format_string_printer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .arg_word   (arg_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .char_count (char_count),
    .is_last    (is_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("format_string_printer test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  task automatic emit_result(input logic [1:0] kind, input logic [7:0] ch);
    print_result_t r;
    if (kind == fsp_pkg::KIND_BYTE && pred_written != COUNT_SAT) pred_written++;
    r.kind  = kind;
    r.ch    = (kind == fsp_pkg::KIND_BYTE) ? ch : 8'h00;
    r.count = pred_written;
    r.last  = 1'b0;
    queued_output.push_back(r);
  endtask

  task automatic fail_stream();
    emit_result(fsp_pkg::KIND_ERR, 8'h00);
    pred_mode    = PM_TEXT;
    pred_written = '0;
  endtask

  task automatic emit_number(input logic [31:0] word, input logic is_signed);
    logic [31:0] mag;
    logic [3:0]  digits [fsp_pkg::DigitDepth];
    int          n;
    mag = word;
    if (is_signed && word[31]) begin
      emit_result(fsp_pkg::KIND_BYTE, fsp_pkg::CH_DASH);
      mag = -word;  // wraps to the true magnitude for the most negative value
    end
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < fsp_pkg::DigitDepth);
    for (int k = n - 1; k >= 0; k--)
      emit_result(fsp_pkg::KIND_BYTE, fsp_pkg::CH_DIGIT0 + {4'h0, digits[k]});
  endtask

  task automatic format_step(input logic [1:0] t, input logic [7:0] b, input logic [31:0] w);
    int n_start;
    n_start = queued_output.size();
    case (pred_mode)
      PM_TEXT: begin
        if (t != fsp_pkg::REQ_FMT) fail_stream();
        else if (b == 8'h00) begin
          emit_result(fsp_pkg::KIND_END, 8'h00);
          pred_written = '0;
        end else if (b == fsp_pkg::CH_PCT) pred_mode = PM_PCT;
        else emit_result(fsp_pkg::KIND_BYTE, b);
      end
      PM_PCT: begin
        if (t != fsp_pkg::REQ_FMT || b == 8'h00) fail_stream();
        else begin
          pred_mode = PM_TEXT;
          case (b)
            fsp_pkg::CH_C:                pred_mode = PM_CHAR;
            fsp_pkg::CH_S:                pred_mode = PM_STR_OPEN;
            fsp_pkg::CH_D, fsp_pkg::CH_I: pred_mode = PM_SIGNED;
            fsp_pkg::CH_U:                pred_mode = PM_UNSIGNED;
            fsp_pkg::CH_PCT:              emit_result(fsp_pkg::KIND_BYTE, fsp_pkg::CH_PCT);
            default: begin
              emit_result(fsp_pkg::KIND_BYTE, fsp_pkg::CH_PCT);
              emit_result(fsp_pkg::KIND_BYTE, b);
            end
          endcase
        end
      end
      PM_CHAR, PM_SIGNED, PM_UNSIGNED: begin
        if (t != fsp_pkg::REQ_NUM) fail_stream();
        else begin
          if (pred_mode == PM_CHAR) emit_result(fsp_pkg::KIND_BYTE, w[7:0]);
          else emit_number(w, pred_mode == PM_SIGNED);
          pred_mode = PM_TEXT;
        end
      end
      PM_STR_OPEN, PM_STR_BODY: begin
        if (t == fsp_pkg::REQ_NULL && pred_mode == PM_STR_OPEN) begin
          for (int i = 0; i < fsp_pkg::NullLen; i++)
            emit_result(fsp_pkg::KIND_BYTE, NULL_TEXT[8*(fsp_pkg::NullLen-1-i) +: 8]);
          pred_mode = PM_TEXT;
        end else if (t != fsp_pkg::REQ_STR) fail_stream();
        else if (b == 8'h00) pred_mode = PM_TEXT;
        else begin
          emit_result(fsp_pkg::KIND_BYTE, b);
          pred_mode = PM_STR_BODY;
        end
      end
      default: fail_stream();
    endcase
    if (queued_output.size() > n_start) queued_output[queued_output.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- request side
  task automatic send_req(input logic [1:0] t, input logic [7:0] b, input logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= t;
    data_byte <= b;
    arg_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    format_step(t, b, w);
    sent_count++;
  endtask

  task automatic send_spec(input logic [7:0] letter);
    send_req(fsp_pkg::REQ_FMT, fsp_pkg::CH_PCT, $urandom);
    send_req(fsp_pkg::REQ_FMT, letter, $urandom);
  endtask

  // hold requests off until the output side has caught up
  task automatic wait_all_printed();
    in_valid <= 1'b0;
    do @(posedge clk); while (queued_output.size() != 0);
  endtask

  // ---------------------------------------------------------------- result side
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    print_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (queued_output.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d byte %h count %0d",
                 $time, out_kind, out_byte, char_count);
      end else begin
        exp_r = queued_output.pop_front();
        check_field("out_kind", 32'(exp_r.kind), 32'(out_kind));
        check_field("out_byte", 32'(exp_r.ch), 32'(out_byte));
        check_field("char_count", 32'(exp_r.count), 32'(char_count));
        check_field("is_last", 32'(exp_r.last), 32'(is_last));
      end
    end
    out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // ---------------------------------------------------------------- random values
  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == fsp_pkg::CH_PCT);
    return b;
  endfunction

  function automatic logic [7:0] rand_unknown_spec();
    logic [7:0] b;
    do b = rand_plain();
    while (b == fsp_pkg::CH_C || b == fsp_pkg::CH_S || b == fsp_pkg::CH_D
           || b == fsp_pkg::CH_I || b == fsp_pkg::CH_U);
    return b;
  endfunction

  function automatic logic [7:0] rand_num_letter();
    case ($urandom_range(2))
      0: return fsp_pkg::CH_D;
      1: return fsp_pkg::CH_I;
      default: return fsp_pkg::CH_U;
    endcase
  endfunction

  function automatic logic [31:0] rand_arg();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 99);
      3: return -$urandom_range(1, 99);
      4: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_plain_text();
    send_req(fsp_pkg::REQ_FMT, 8'h01, 32'h0);
    send_req(fsp_pkg::REQ_FMT, 8'hFF, 32'hFFFF_FFFF);
    send_req(fsp_pkg::REQ_FMT, 8'h00, 32'h0);
  endtask

  task automatic test_integers();
    send_spec(fsp_pkg::CH_D);
    send_req(fsp_pkg::REQ_NUM, 8'hFF, 32'h8000_0000);
    send_spec(fsp_pkg::CH_I);
    send_req(fsp_pkg::REQ_NUM, 8'h00, 32'hFFFF_FFFF);
    send_spec(fsp_pkg::CH_U);
    send_req(fsp_pkg::REQ_NUM, 8'h5A, 32'hFFFF_FFFF);
    send_req(fsp_pkg::REQ_FMT, 8'h00, 32'h0);
  endtask

  task automatic test_chars_strings();
    send_spec(fsp_pkg::CH_C);
    send_req(fsp_pkg::REQ_NUM, 8'h00, 32'hFFFF_FF7E);
    send_spec(fsp_pkg::CH_S);
    send_req(fsp_pkg::REQ_STR, 8'h00, 32'h0);
    send_spec(fsp_pkg::CH_S);
    send_req(fsp_pkg::REQ_NULL, 8'hA5, 32'h1234_5678);
    send_spec(fsp_pkg::CH_PCT);
    send_spec(8'h71);
    send_req(fsp_pkg::REQ_FMT, 8'h00, 32'h0);
  endtask

  task automatic test_format_errors();
    send_req(fsp_pkg::REQ_FMT, fsp_pkg::CH_PCT, 32'h0);
    send_req(fsp_pkg::REQ_FMT, 8'h00, 32'h0);     // lone trailing percent
    send_req(fsp_pkg::REQ_NUM, 8'h41, 32'h7);     // argument with nothing awaited
    send_spec(fsp_pkg::CH_D);
    send_req(fsp_pkg::REQ_STR, 8'h31, 32'h0);     // string byte for an integer
    send_spec(fsp_pkg::CH_S);
    send_req(fsp_pkg::REQ_STR, 8'h61, 32'h0);
    send_req(fsp_pkg::REQ_NULL, 8'h00, 32'h0);    // null after string bytes started
    send_spec(fsp_pkg::CH_C);
    send_req(fsp_pkg::REQ_FMT, 8'h78, 32'h0);     // format byte while argument awaited
    send_spec(fsp_pkg::CH_S);
    send_req(fsp_pkg::REQ_NUM, 8'h00, 32'h55);    // number for a string
  endtask

  task automatic test_random(input int n_items);
    int          target;
    int          half;
    int          sel;
    int          len;
    logic [7:0]  letter;
    logic [1:0]  t;
    logic        paused;
    target = sent_count + n_items;
    half   = sent_count + n_items / 2;
    paused = 1'b0;
    while (sent_count < target) begin
      sel = $urandom_range(99);
      if (sel < 40) send_req(fsp_pkg::REQ_FMT, rand_plain(), $urandom);
      else if (sel < 55) begin
        send_spec(rand_num_letter());
        send_req(fsp_pkg::REQ_NUM, 8'($urandom), rand_arg());
      end else if (sel < 62) begin
        send_spec(fsp_pkg::CH_C);
        send_req(fsp_pkg::REQ_NUM, 8'($urandom), $urandom);
      end else if (sel < 72) begin
        send_spec(fsp_pkg::CH_S);
        if ($urandom_range(4) == 0) send_req(fsp_pkg::REQ_NULL, 8'($urandom), $urandom);
        else begin
          len = $urandom_range(5);
          repeat (len) send_req(fsp_pkg::REQ_STR, 8'($urandom_range(1, 255)), $urandom);
          send_req(fsp_pkg::REQ_STR, 8'h00, $urandom);
        end
      end else if (sel < 76) send_spec(fsp_pkg::CH_PCT);
      else if (sel < 80) send_spec(rand_unknown_spec());
      else if (sel < 88) send_req(fsp_pkg::REQ_FMT, 8'h00, $urandom);
      else if (sel < 93) send_req(2'($urandom), 8'($urandom), $urandom);
      else if (sel < 96) begin
        send_req(fsp_pkg::REQ_FMT, fsp_pkg::CH_PCT, $urandom);
        send_req(fsp_pkg::REQ_FMT, 8'h00, $urandom);
      end else begin
        // broken argument: pick a type that does not fit the specifier
        if ($urandom_range(1) == 0) letter = fsp_pkg::CH_S;
        else if ($urandom_range(1) == 0) letter = fsp_pkg::CH_C;
        else letter = rand_num_letter();
        send_spec(letter);
        if (letter == fsp_pkg::CH_S && $urandom_range(2) == 0) begin
          send_req(fsp_pkg::REQ_STR, rand_plain(), $urandom);
          send_req(fsp_pkg::REQ_NULL, 8'($urandom), $urandom);
        end else begin
          if (letter == fsp_pkg::CH_S)
            t = ($urandom_range(1) == 0) ? fsp_pkg::REQ_FMT : fsp_pkg::REQ_NUM;
          else do t = 2'($urandom); while (t == fsp_pkg::REQ_NUM);
          send_req(t, 8'($urandom), $urandom);
        end
      end
      if (!paused && sent_count >= half) begin
        paused = 1'b1;
        wait_all_printed();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_text();
    test_integers();
    test_chars_strings();
    test_format_errors();
    test_random(140);
    wait_all_printed();
    send_idle = 51;
    recv_idle = 38;
    test_random(150);
    wait_all_printed();
    send_idle = 0;
    recv_idle = 0;
    test_random(150);
    wait_all_printed();
    repeat (30) @(posedge clk);
    if (errors == 0) $display("format_string_printer test passed");
    else $display("format_string_printer test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/fsp_pkg.sv
rtl/fsp_datapath.sv
rtl/fsp_ctrl.sv
rtl/format_string_printer.sv
rtl/fsp_checker.sv
tb/tb_format_string_printer.sv
